// ===== rtl/scb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scb_pkg;

  // History depth in entries. The ring addressing assumes a power of two.
  localparam int HISTORY_DEPTH = 128;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int COUNT_W       = $clog2(HISTORY_DEPTH + 1);
  localparam int SAMPLE_NIB_W  = 4;

  // Widest draw in characters: the lesser of the history depth over eight and a hard cap of sixteen.
  localparam int MAX_CHARS     = 16;
  localparam int CHAR_LIMIT    = (HISTORY_DEPTH / 8 < MAX_CHARS) ?
                                 (HISTORY_DEPTH / 8) : MAX_CHARS;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_HOLD
  } state_t;

  // Bar byte for one history nibble: level v sets the top v+1 bits.
  function automatic logic [7:0] bar_byte(input logic [SAMPLE_NIB_W-1:0] nib);
    logic [2:0] gap;
    gap = 3'd7 - nib[3:1];
    return (8'hFF >> gap) << gap;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/scb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scb_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scrolling_bar_graph_columns_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A push word writes the sample nibble to the history RAM.
// A draw of N characters, N saturated to CHAR_LIMIT, returns N result words; each is
// built through the single RAM read port by eight reads, a capture and a hand-off.
// Synchronous active-low reset clears the write pointer, the valid count, the
// sequencer and the output valid; the history RAM itself is not cleared.

module scrolling_bar_graph_columns_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [7:0]  in_sample,
  input  wire logic [4:0]  in_char_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_column_bytes,
  output logic             out_last_group
);

  import scb_pkg::*;

  // The history is a ring in RAM. wr_ptr_r points at the slot the next push
  // fills, so logical position p (0 oldest, DEPTH-1 newest) lives at physical
  // address wr_ptr_r + p, wrapping naturally in HIST_AW bits.
  state_t                  state_r, state_nxt;
  logic [HIST_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [COUNT_W-1:0]      valid_count_r, valid_count_nxt;

  // Draw bookkeeping: position of the next column to fetch, groups still to
  // send, and the column issue counter within the current group.
  logic [HIST_AW-1:0]      pos_r, pos_nxt;
  logic [4:0]              groups_left_r, groups_left_nxt;
  logic [3:0]              cnt_r, cnt_nxt;

  // Read pipeline: the RAM returns data in the cycle after the address, so the
  // column index and its in-window flag travel alongside.
  logic                    rd_v_r;
  logic                    rd_ok_r;
  logic [2:0]              rd_j_r;
  logic [63:0]             asm_r, asm_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [63:0]             out_bytes_r;
  logic                    out_last_r;

  // Control decoded from the state.
  logic                    accept;
  logic                    do_push;
  logic                    do_draw;
  logic                    issue;
  logic                    out_load;

  logic [4:0]              chars_sat;
  logic [COUNT_W-1:0]      first_pos;
  logic [COUNT_W-1:0]      oldest_valid;
  logic                    col_ok;
  logic [SAMPLE_NIB_W-1:0] ram_rdata;

  // Width saturates to the largest window the history can supply.
  assign chars_sat = (in_char_count > 5'(CHAR_LIMIT)) ? 5'(CHAR_LIMIT) : in_char_count;
  assign first_pos = COUNT_W'(HISTORY_DEPTH) - COUNT_W'({chars_sat, 3'b000});

  // Columns older than the valid entries are drawn blank.
  assign oldest_valid = COUNT_W'(HISTORY_DEPTH) - valid_count_r;
  assign col_ok       = COUNT_W'(pos_r) >= oldest_valid;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_func == FUNC_DRAW) && (chars_sat != 5'd0)) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (cnt_r == 4'd8) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = (groups_left_r == 5'd1) ? ST_IDLE : ST_FETCH;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output and control decode.
  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_FETCH: issue    = (cnt_r != 4'd8);
      ST_HOLD:  out_load = !out_valid_r || !out_stall;
      default:  in_stall = 1'b1;
    endcase
  end

  assign accept  = in_valid && !in_stall;
  assign do_push = accept && (in_func == FUNC_PUSH);
  assign do_draw = accept && (in_func == FUNC_DRAW) && (chars_sat != 5'd0);

  // Datapath next values.
  always_comb begin
    wr_ptr_nxt      = wr_ptr_r;
    valid_count_nxt = valid_count_r;
    pos_nxt         = pos_r;
    groups_left_nxt = groups_left_r;
    cnt_nxt         = cnt_r;
    asm_nxt         = asm_r;
    out_valid_nxt   = out_valid_r;

    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
      if (valid_count_r != COUNT_W'(HISTORY_DEPTH)) begin
        valid_count_nxt = valid_count_r + 1'b1;
      end
    end

    if (do_draw) begin
      pos_nxt         = first_pos[HIST_AW-1:0];
      groups_left_nxt = chars_sat;
      cnt_nxt         = 4'd0;
    end

    if (issue) begin
      pos_nxt = pos_r + 1'b1;
      cnt_nxt = cnt_r + 4'd1;
    end

    if (rd_v_r) begin
      asm_nxt[{rd_j_r, 3'b000} +: 8] = rd_ok_r ? bar_byte(ram_rdata) : 8'h00;
    end

    if (out_load) begin
      groups_left_nxt = groups_left_r - 5'd1;
      cnt_nxt         = 4'd0;
      out_valid_nxt   = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      wr_ptr_r      <= '0;
      valid_count_r <= '0;
      groups_left_r <= '0;
      cnt_r         <= '0;
      rd_v_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      wr_ptr_r      <= wr_ptr_nxt;
      valid_count_r <= valid_count_nxt;
      groups_left_r <= groups_left_nxt;
      cnt_r         <= cnt_nxt;
      rd_v_r        <= issue;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    rd_ok_r <= col_ok;
    rd_j_r  <= cnt_r[2:0];
    asm_r   <= asm_nxt;
    if (out_load) begin
      out_bytes_r <= asm_r;
      out_last_r  <= (groups_left_r == 5'd1);
    end
  end

  // Pushes happen only in idle and reads only while fetching, so a write and
  // a read of the same entry never share a cycle.
  scb_ram #(
    .WIDTH (SAMPLE_NIB_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (wr_ptr_r),
    .wdata (in_sample[7:4]),
    .re    (issue),
    .raddr (wr_ptr_r + pos_r),
    .rdata (ram_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_column_bytes = out_bytes_r;
  assign out_last_group   = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/scb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_func,
  input wire logic [4:0]  in_char_count,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_column_bytes,
  input wire logic        out_last_group
);

  import scb_pkg::*;

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_column_bytes) && $stable(out_last_group))
    else $error("result payload changed while stalled");

  // A push leaves the input open in the following cycle.
  a_push_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func == FUNC_PUSH) |=> !in_stall)
    else $error("input stalled after a push");

  // A nonempty draw occupies the block while it fetches.
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func == FUNC_DRAW) && (in_char_count != 5'd0)
    |=> in_stall)
    else $error("input open during a draw");

endmodule

bind scrolling_bar_graph_columns_core scb_checker u_scb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_func          (in_func),
  .in_char_count    (in_char_count),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_column_bytes (out_column_bytes),
  .out_last_group   (out_last_group)
);

`default_nettype wire

// ===== dv/bar_graph_column_checker.sv =====
`timescale 1ns / 1ps

module bar_graph_column_checker
  import scb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic        in_func,
  input  wire logic [7:0]  in_sample,
  input  wire logic [4:0]  in_char_count,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [63:0] out_column_bytes,
  input  wire logic        out_last_group,
  output int               fail_count,
  output int               groups_owed
);

  typedef struct packed {
    logic [63:0] column_bytes;
    logic        last_group;
  } bar_group_t;

  logic [3:0]  level_history [HISTORY_DEPTH];
  int          filled_entries;
  bar_group_t  owed_groups [$];
  int          mismatches;

  // Level v lights the top v+1 pixels of the column.
  function automatic logic [7:0] column_pixels(logic [3:0] nib);
    int lvl;
    lvl = nib >> 1;
    return ~(8'hFF >> (lvl + 1));
  endfunction

  task automatic shift_in_sample(logic [7:0] sample);
    for (int i = 0; i < HISTORY_DEPTH - 1; i++) level_history[i] = level_history[i + 1];
    level_history[HISTORY_DEPTH - 1] = sample[7:4];
    if (filled_entries < HISTORY_DEPTH) filled_entries++;
  endtask

  task automatic render_window(logic [4:0] char_count);
    int         chars;
    int         first_col;
    int         oldest_col;
    int         col;
    bar_group_t grp;
    chars = (char_count > CHAR_LIMIT) ? CHAR_LIMIT : char_count;
    first_col = HISTORY_DEPTH - 8 * chars;
    oldest_col = HISTORY_DEPTH - filled_entries;
    for (int g = 0; g < chars; g++) begin
      grp.column_bytes = '0;
      for (int j = 0; j < 8; j++) begin
        col = first_col + 8 * g + j;
        if (col >= oldest_col) grp.column_bytes[8 * j +: 8] = column_pixels(level_history[col]);
      end
      grp.last_group = (g == chars - 1);
      owed_groups.push_back(grp);
    end
  endtask

  initial begin
    for (int i = 0; i < HISTORY_DEPTH; i++) level_history[i] = '0;
    filled_entries = 0;
    mismatches = 0;
    fail_count = 0;
    groups_owed = 0;
  end

  always @(posedge clk) begin
    bar_group_t want;
    if (!rst_n) begin
      owed_groups.delete();
      filled_entries = 0;
    end else begin
      // Results are taken before new words, since a draw accepted now cannot
      // have produced anything yet.
      if (out_valid && !out_stall) begin
        if (owed_groups.size() == 0) begin
          $error("unexpected result word: column_bytes %h last_group %b",
                 out_column_bytes, out_last_group);
          mismatches++;
        end else begin
          want = owed_groups.pop_front();
          if (out_column_bytes !== want.column_bytes) begin
            $error("column_bytes: expected %h, actual %h", want.column_bytes, out_column_bytes);
            mismatches++;
          end
          if (out_last_group !== want.last_group) begin
            $error("last_group: expected %b, actual %b", want.last_group, out_last_group);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_func == FUNC_PUSH) shift_in_sample(in_sample);
        else render_window(in_char_count);
      end
    end
    fail_count <= mismatches;
    groups_owed <= owed_groups.size();
  end

endmodule

// ===== dv/scrolling_bar_graph_columns_core_tb.sv =====
`timescale 1ns / 1ps

module scrolling_bar_graph_columns_core_tb;
  import scb_pkg::*;

  // Pacing of the two channels. Steady means no gaps on either side.
  typedef enum logic [1:0] {
    PACE_STEADY,
    PACE_SENDER_GAPS,
    PACE_SINK_STALLS,
    PACE_BOTH
  } pace_t;

  // Generous ceiling: a few dozen draws of up to sixteen groups, each group
  // with its reads and the longest random stall, and the long hold-off, with
  // ample room on top.
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_func = FUNC_PUSH;
  logic [7:0]  in_sample = '0;
  logic [4:0]  in_char_count = '0;
  logic        out_stall = 1'b0;
  wire logic        in_stall;
  wire logic        out_valid;
  wire logic [63:0] out_column_bytes;
  wire logic        out_last_group;

  pace_t pace = PACE_STEADY;
  logic  hold_req = 1'b0;
  int    fail_count;
  int    groups_owed;
  int    cycles = 0;
  int    words_sent = 0;
  int    pushes_sent = 0;

  scrolling_bar_graph_columns_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_sample        (in_sample),
    .in_char_count    (in_char_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_column_bytes (out_column_bytes),
    .out_last_group   (out_last_group)
  );

  // The checker sits beside the block, watches both channels, predicts every
  // result word and reports how many mismatches it saw and how many words it
  // is still owed.
  bar_graph_column_checker checker_inst (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_sample        (in_sample),
    .in_char_count    (in_char_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_column_bytes (out_column_bytes),
    .out_last_group   (out_last_group),
    .fail_count       (fail_count),
    .groups_owed      (groups_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side. A hold-off request forces the stall high for a long stretch
  // counted here, once; otherwise the stall follows the current pace.
  always @(posedge clk) begin
    int hold_left;
    bit hold_taken;
    if (hold_req && !hold_taken) begin
      hold_left = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      case (pace)
        PACE_SINK_STALLS: out_stall <= ($urandom_range(0, 99) < 66);
        PACE_BOTH:        out_stall <= ($urandom_range(0, 99) < 13);
        default:          out_stall <= 1'b0;
      endcase
    end
  end

  // Watchdog: a run that has not finished by the ceiling has hung.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[scrolling_bar_graph_columns_core] ERROR");
    $finish;
  end

  // Offers one word, with random gaps ahead of it when the pace calls for
  // them, and returns at the edge where the block takes it.
  task automatic send_word(logic func, logic [7:0] sample, logic [4:0] char_count);
    int gap_pct;
    gap_pct = (pace == PACE_SENDER_GAPS) ? 66 : (pace == PACE_BOTH) ? 13 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= func;
    in_sample     <= sample;
    in_char_count <= char_count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (func == FUNC_PUSH) pushes_sent++;
  endtask

  // Stops offering and waits until every predicted result word has come.
  // The extra edge lets the checker's count catch up with the last word.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (groups_owed != 0) @(posedge clk);
  endtask

  // Samples are uniform most of the time, with the extremes and the level
  // boundaries mixed in so that the low edge of each upper nibble shows up often.
  function automatic logic [7:0] pick_sample();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 8'h00;
    if (roll < 20) return 8'hFF;
    if (roll < 30) return {4'($urandom_range(0, 15)), 4'h0};
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int       burst;
    int       roll;
    logic [4:0] width;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. An empty history draws nothing but blank columns, and a
    // zero width draws nothing at all.
    send_word(FUNC_DRAW, 8'h00, 5'd16);
    send_word(FUNC_DRAW, 8'hFF, 5'd0);
    // Extremes and level boundaries of the sample field.
    send_word(FUNC_PUSH, 8'hFF, 5'd0);
    send_word(FUNC_PUSH, 8'h00, 5'd31);
    send_word(FUNC_PUSH, 8'h10, 5'd0);
    send_word(FUNC_PUSH, 8'h2F, 5'd0);
    send_word(FUNC_PUSH, 8'h80, 5'd0);
    send_word(FUNC_PUSH, 8'h7F, 5'd0);
    // A one-character window mixes missing columns with real ones.
    send_word(FUNC_DRAW, 8'h00, 5'd1);
    // Oversized widths saturate to the full sixteen characters.
    send_word(FUNC_DRAW, 8'h00, 5'd31);
    send_word(FUNC_DRAW, 8'hFF, 5'd17);
    send_word(FUNC_PUSH, 8'hF0, 5'd0);
    send_word(FUNC_PUSH, 8'h0F, 5'd0);
    send_word(FUNC_PUSH, 8'hAA, 5'd21);
    send_word(FUNC_PUSH, 8'h55, 5'd10);
    send_word(FUNC_DRAW, 8'h00, 5'd2);
    // The sample field is ignored by a draw.
    send_word(FUNC_DRAW, 8'hFF, 5'd8);
    send_word(FUNC_DRAW, 8'h5A, 5'd16);

    // Let everything come out before the hold-off scene.
    drain_results();

    // Long hold-off on the result side while words keep coming, so the block
    // backs up and stalls its input.
    hold_req <= 1'b1;
    send_word(FUNC_DRAW, 8'h00, 5'd16);
    repeat (6) send_word(FUNC_PUSH, pick_sample(), 5'($urandom_range(0, 31)));
    send_word(FUNC_DRAW, 8'h00, 5'd16);
    repeat (4) send_word(FUNC_PUSH, pick_sample(), 5'($urandom_range(0, 31)));
    send_word(FUNC_DRAW, 8'h00, 5'd3);
    drain_results();

    // Random part: bursts of pushes, each closed by a draw. Most draws are
    // narrow to keep the run short; some are full width or oversized, and a
    // few have zero width. The push count runs past the history depth so
    // that the valid count saturates and later draws see a full window.
    burst = 0;
    while (words_sent < 150 || pushes_sent < 132) begin
      pace <= pace_t'((burst / 5) % 4);
      repeat ($urandom_range(1, 14))
        send_word(FUNC_PUSH, pick_sample(), 5'($urandom_range(0, 31)));
      roll = $urandom_range(0, 99);
      if (roll < 65) width = 5'($urandom_range(1, 4));
      else if (roll < 80) width = 5'($urandom_range(5, 15));
      else if (roll < 94) width = 5'($urandom_range(16, 31));
      else width = 5'd0;
      send_word(FUNC_DRAW, 8'($urandom_range(0, 255)), width);
      burst++;
    end

    pace <= PACE_STEADY;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && groups_owed == 0) begin
      $display("[scrolling_bar_graph_columns_core] OK");
    end else begin
      $display("[scrolling_bar_graph_columns_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== scrolling_bar_graph_columns_core.f =====
rtl/scb_pkg.sv
rtl/scb_ram.sv
rtl/scrolling_bar_graph_columns_core.sv
rtl/scb_checker.sv
dv/bar_graph_column_checker.sv
dv/scrolling_bar_graph_columns_core_tb.sv
